[src/dltr_pkg.sv]
package dltr_pkg;

   localparam int LINE_W = 8;
   localparam int DATA_W = 8;
   localparam int ADDR_W = 8;
   localparam int TIMER_W = 16;
   localparam int VISIBLE_LINES_DEFAULT = 144;

   localparam logic [1:0] KIND_READ  = 2'd0;
   localparam logic [1:0] KIND_WRITE = 2'd1;
   localparam logic [1:0] KIND_TICK  = 2'd2;

   localparam logic [ADDR_W-1:0] ADDR_LINE        = 8'h02;
   localparam logic [ADDR_W-1:0] ADDR_LINE_CMP    = 8'h03;
   localparam logic [ADDR_W-1:0] ADDR_SPRITE_BASE = 8'h04;
   localparam logic [ADDR_W-1:0] ADDR_PLAIN_HI    = 8'h15;
   localparam logic [ADDR_W-1:0] ADDR_VTOTAL      = 8'h16;
   localparam logic [ADDR_W-1:0] ADDR_SHADE_LO    = 8'h1C;
   localparam logic [ADDR_W-1:0] ADDR_SHADE_HI    = 8'h1F;
   localparam logic [ADDR_W-1:0] ADDR_MONO_LO     = 8'h20;
   localparam logic [ADDR_W-1:0] ADDR_MONO_HI     = 8'h3F;
   localparam logic [ADDR_W-1:0] ADDR_LAST_PLAIN  = 8'h60;
   localparam logic [ADDR_W-1:0] ADDR_MODEL_ID    = 8'hA0;
   localparam logic [ADDR_W-1:0] ADDR_TMR_CTRL    = 8'hA2;
   localparam logic [ADDR_W-1:0] ADDR_HPER_LO     = 8'hA4;
   localparam logic [ADDR_W-1:0] ADDR_HPER_HI     = 8'hA5;
   localparam logic [ADDR_W-1:0] ADDR_VPER_LO     = 8'hA6;
   localparam logic [ADDR_W-1:0] ADDR_VPER_HI     = 8'hA7;
   localparam logic [ADDR_W-1:0] ADDR_HCNT_LO     = 8'hA8;
   localparam logic [ADDR_W-1:0] ADDR_HCNT_HI     = 8'hA9;
   localparam logic [ADDR_W-1:0] ADDR_VCNT_LO     = 8'hAA;
   localparam logic [ADDR_W-1:0] ADDR_VCNT_HI     = 8'hAB;

   localparam logic [DATA_W-1:0] ID_MONO  = 8'h86;
   localparam logic [DATA_W-1:0] ID_COLOR = 8'h87;

   localparam logic [LINE_W-1:0] LINE_CMP_RESET = 8'hBB;
   localparam logic [LINE_W-1:0] VTOTAL_RESET   = 8'd158;

   localparam logic [DATA_W-1:0] SPRITE_BASE_MASK = 8'h3F;

   localparam int TC_HBLANK_EN   = 0;
   localparam int TC_HBLANK_LOOP = 1;
   localparam int TC_VBLANK_EN   = 2;
   localparam int TC_VBLANK_LOOP = 3;

   typedef struct packed {
      logic [1:0]        kind;
      logic [ADDR_W-1:0] address;
      logic [DATA_W-1:0] write_data;
   } req_type;

   typedef struct packed {
      logic [DATA_W-1:0] read_data;
      logic              vblank_irq;
      logic              vblank_timer_irq;
      logic              hblank_timer_irq;
      logic              line_hit_irq;
      logic              frame_end;
   } rsp_type;

   typedef struct packed {
      logic [LINE_W-1:0] line_compare;
      logic [LINE_W-1:0] vertical_total;
   } line_cfg_type;

   typedef struct packed {
      logic vblank_irq;
      logic vblank_timer_irq;
      logic hblank_timer_irq;
      logic line_hit_irq;
      logic frame_end;
   } event_type;

endpackage

[src/dltr_regs.sv]
module dltr_regs
   import dltr_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              step,
   input  req_type           item,
   output logic [DATA_W-1:0] read_data,
   output line_cfg_type      line_cfg
);

   localparam int PLAIN_N = 22;
   localparam int SLOT_W  = $clog2(PLAIN_N);
   localparam int SHADE_N = 4;
   localparam int MONO_N  = 32;

   logic [DATA_W-1:0] plain_ff [PLAIN_N];
   logic [DATA_W-1:0] shade_ff [SHADE_N];
   logic [5:0]        mono_ff  [MONO_N];
   logic [LINE_W-1:0] line_cmp_ff;
   logic [LINE_W-1:0] vtotal_ff;

   logic              plain_hit;
   logic [SLOT_W-1:0] plain_slot;
   logic              shade_hit;
   logic              mono_hit;
   logic              do_write;
   logic [DATA_W-1:0] plain_wdata;

   // Ports 0x00, 0x01, 0x04..0x15 and 0x60 share one packed register bank.
   always_comb begin
      plain_hit  = 1'b0;
      plain_slot = '0;
      if (item.address <= 8'h01) begin
         plain_hit  = 1'b1;
         plain_slot = SLOT_W'(item.address);
      end else if (item.address >= ADDR_SPRITE_BASE && item.address <= ADDR_PLAIN_HI) begin
         plain_hit  = 1'b1;
         plain_slot = SLOT_W'(item.address - ADDR_SPRITE_BASE + 8'd2);
      end else if (item.address == ADDR_LAST_PLAIN) begin
         plain_hit  = 1'b1;
         plain_slot = SLOT_W'(PLAIN_N - 1);
      end
   end

   assign shade_hit = (item.address >= ADDR_SHADE_LO) && (item.address <= ADDR_SHADE_HI);
   assign mono_hit  = (item.address >= ADDR_MONO_LO) && (item.address <= ADDR_MONO_HI);
   assign do_write  = step && (item.kind == KIND_WRITE);
   assign plain_wdata = (item.address == ADDR_SPRITE_BASE) ?
                        (item.write_data & SPRITE_BASE_MASK) : item.write_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < PLAIN_N; i++) begin
            plain_ff[i] <= '0;
         end
         for (int i = 0; i < SHADE_N; i++) begin
            shade_ff[i] <= '0;
         end
         for (int i = 0; i < MONO_N; i++) begin
            mono_ff[i] <= '0;
         end
         line_cmp_ff <= LINE_CMP_RESET;
         vtotal_ff   <= VTOTAL_RESET;
      end else if (do_write) begin
         if (shade_hit) begin
            shade_ff[item.address[1:0]] <= item.write_data;
         end else if (mono_hit) begin
            mono_ff[item.address[4:0]] <= {item.write_data[6:4], item.write_data[2:0]};
         end else if (plain_hit) begin
            plain_ff[plain_slot] <= plain_wdata;
         end else if (item.address == ADDR_LINE_CMP) begin
            line_cmp_ff <= item.write_data;
         end else if (item.address == ADDR_VTOTAL) begin
            vtotal_ff <= item.write_data;
         end
      end
   end

   always_comb begin
      read_data = '0;
      if (shade_hit) begin
         read_data = shade_ff[item.address[1:0]];
      end else if (mono_hit) begin
         read_data = {1'b0, mono_ff[item.address[4:0]][5:3],
                      1'b0, mono_ff[item.address[4:0]][2:0]};
      end else if (plain_hit) begin
         read_data = plain_ff[plain_slot];
      end else if (item.address == ADDR_LINE_CMP) begin
         read_data = line_cmp_ff;
      end else if (item.address == ADDR_VTOTAL) begin
         read_data = vtotal_ff;
      end
   end

   assign line_cfg.line_compare   = line_cmp_ff;
   assign line_cfg.vertical_total = vtotal_ff;

endmodule

[src/dltr_timing.sv]
module dltr_timing
   import dltr_pkg::*;
#(
   parameter int VISIBLE_LINES = VISIBLE_LINES_DEFAULT
)
(
   input  logic              clock,
   input  logic              reset,
   input  logic              step,
   input  req_type           item,
   input  line_cfg_type      line_cfg,
   output logic [DATA_W-1:0] read_data,
   output event_type         events
);

   localparam logic [LINE_W-1:0] VIS_LINE = LINE_W'(VISIBLE_LINES);

   logic [LINE_W-1:0]  line_ff,      line_in;
   logic [DATA_W-1:0]  tctl_ff,      tctl_in;
   logic [TIMER_W-1:0] hper_ff,      hper_in;
   logic [TIMER_W-1:0] vper_ff,      vper_in;
   logic [TIMER_W-1:0] hcnt_ff,      hcnt_in;
   logic [TIMER_W-1:0] vcnt_ff,      vcnt_in;
   logic               frame_sel_ff, frame_sel_in;

   logic               at_vis;
   logic [TIMER_W-1:0] hcnt_dec;
   logic [TIMER_W-1:0] vcnt_dec;
   logic               h_step;
   logic               v_step;
   logic [LINE_W-1:0]  line_limit_base;
   logic [LINE_W:0]    line_limit;
   logic [LINE_W-1:0]  line_next;

   // Remainder of a value of at most 2^LINE_W by a divisor of at least
   // VISIBLE_LINES + 1. Only the compare-subtract steps whose shifted minimum
   // divisor still fits under 2^LINE_W can ever subtract, so the others are
   // dropped; with the default line count a single step remains.
   function automatic logic [LINE_W-1:0] line_wrap(input logic [LINE_W:0] num,
                                                   input logic [LINE_W:0] den);
      logic [2*LINE_W:0] rem;
      logic [2*LINE_W:0] sub;
      rem = {{LINE_W{1'b0}}, num};
      for (int i = LINE_W - 1; i >= 0; i--) begin
         if (((VISIBLE_LINES + 1) << i) <= (1 << LINE_W)) begin
            sub = {{LINE_W{1'b0}}, den} << i;
            if (rem >= sub) begin
               rem = rem - sub;
            end
         end
      end
      return rem[LINE_W-1:0];
   endfunction

   assign at_vis   = (line_ff == VIS_LINE);
   assign hcnt_dec = hcnt_ff - 1'b1;
   assign vcnt_dec = vcnt_ff - 1'b1;
   assign h_step   = (hcnt_ff != '0) && tctl_ff[TC_HBLANK_EN];
   assign v_step   = at_vis && (vcnt_ff != '0) && tctl_ff[TC_VBLANK_EN];

   assign line_limit_base = (line_cfg.vertical_total >= VIS_LINE) ?
                            line_cfg.vertical_total : VIS_LINE;
   assign line_limit      = {1'b0, line_limit_base} + 1'b1;
   assign line_next       = line_wrap({1'b0, line_ff} + 1'b1, line_limit);

   always_comb begin
      line_in      = line_ff;
      tctl_in      = tctl_ff;
      hper_in      = hper_ff;
      vper_in      = vper_ff;
      hcnt_in      = hcnt_ff;
      vcnt_in      = vcnt_ff;
      frame_sel_in = frame_sel_ff;
      events       = '0;

      if (item.kind == KIND_TICK) begin
         events.frame_end  = at_vis;
         events.vblank_irq = at_vis;
         if (at_vis) begin
            frame_sel_in = ~frame_sel_ff;
         end
         if (v_step) begin
            vcnt_in = vcnt_dec;
            if (vcnt_dec == '0) begin
               events.vblank_timer_irq = 1'b1;
               if (tctl_ff[TC_VBLANK_LOOP]) begin
                  vcnt_in = vper_ff;
               end
            end
         end
         if (h_step) begin
            hcnt_in = hcnt_dec;
            if (hcnt_dec == '0) begin
               events.hblank_timer_irq = 1'b1;
               if (tctl_ff[TC_HBLANK_LOOP]) begin
                  hcnt_in = hper_ff;
               end
            end
         end
         line_in             = line_next;
         events.line_hit_irq = (line_next == line_cfg.line_compare);
      end else if (item.kind == KIND_WRITE) begin
         case (item.address)
            ADDR_TMR_CTRL: tctl_in = item.write_data;
            ADDR_HPER_LO:  hper_in = {hper_ff[TIMER_W-1:DATA_W], item.write_data};
            ADDR_HPER_HI: begin
               hper_in = {item.write_data, hper_ff[DATA_W-1:0]};
               hcnt_in = {item.write_data, hper_ff[DATA_W-1:0]};
            end
            ADDR_VPER_LO:  vper_in = {vper_ff[TIMER_W-1:DATA_W], item.write_data};
            ADDR_VPER_HI: begin
               vper_in = {item.write_data, vper_ff[DATA_W-1:0]};
               vcnt_in = {item.write_data, vper_ff[DATA_W-1:0]};
            end
            default: ;
         endcase
      end
   end

   always_comb begin
      case (item.address)
         ADDR_LINE:     read_data = line_ff;
         ADDR_TMR_CTRL: read_data = tctl_ff;
         ADDR_HPER_LO:  read_data = hper_ff[DATA_W-1:0];
         ADDR_HPER_HI:  read_data = hper_ff[TIMER_W-1:DATA_W];
         ADDR_VPER_LO:  read_data = vper_ff[DATA_W-1:0];
         ADDR_VPER_HI:  read_data = vper_ff[TIMER_W-1:DATA_W];
         ADDR_HCNT_LO:  read_data = hcnt_ff[DATA_W-1:0];
         ADDR_HCNT_HI:  read_data = hcnt_ff[TIMER_W-1:DATA_W];
         ADDR_VCNT_LO:  read_data = vcnt_ff[DATA_W-1:0];
         ADDR_VCNT_HI:  read_data = vcnt_ff[TIMER_W-1:DATA_W];
         default:       read_data = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_ff      <= '0;
         tctl_ff      <= '0;
         hper_ff      <= '0;
         vper_ff      <= '0;
         hcnt_ff      <= '0;
         vcnt_ff      <= '0;
         frame_sel_ff <= 1'b0;
      end else if (step) begin
         line_ff      <= line_in;
         tctl_ff      <= tctl_in;
         hper_ff      <= hper_in;
         vper_ff      <= vper_in;
         hcnt_ff      <= hcnt_in;
         vcnt_ff      <= vcnt_in;
         frame_sel_ff <= frame_sel_in;
      end
   end

endmodule

[src/display_line_timer_registers_unit.sv]
// Display register port with scanline counter and two blank timers. Each item
// is a register read, a register write or one scanline tick, and each gives
// exactly one result: read data for a read, interrupt and frame-end flags for
// a tick, all zeros otherwise. An item is held in the input register, then
// resolved against the register file into the result register; an item can be
// accepted every cycle while results are taken, and while a result waits the
// input register still takes one more item. The tick path (timer decrement,
// line advance with wrap at the larger of VISIBLE_LINES and the vertical total
// plus one, line compare) is resolved combinationally in that step. All
// storage but the two item registers is cleared or preset by reset; the model
// id register selects the color id and may only be written while idle.
module display_line_timer_registers_unit
   import dltr_pkg::*;
#(
   parameter int VISIBLE_LINES = VISIBLE_LINES_DEFAULT
)
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_payload,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_payload,
   input  logic    csr_write_enable,
   input  logic    csr_write_data
);

   logic    in_vld_ff,  in_vld_in;
   req_type in_item_ff;
   logic    out_vld_ff, out_vld_in;
   rsp_type out_item_ff, out_item_in;
   logic    color_ff;

   logic              advance;
   logic [DATA_W-1:0] regs_rdata;
   logic [DATA_W-1:0] tim_rdata;
   logic [DATA_W-1:0] id_rdata;
   line_cfg_type      line_cfg;
   event_type         events;

   assign advance   = in_vld_ff && (!out_vld_ff || rsp_ready);
   assign req_ready = !in_vld_ff || advance;

   always_comb begin
      in_vld_in = in_vld_ff;
      if (req_valid && req_ready) begin
         in_vld_in = 1'b1;
      end else if (advance) begin
         in_vld_in = 1'b0;
      end
      out_vld_in = out_vld_ff;
      if (advance) begin
         out_vld_in = 1'b1;
      end else if (rsp_ready) begin
         out_vld_in = 1'b0;
      end
   end

   dltr_regs u_regs (
      .clock     (clock),
      .reset     (reset),
      .step      (advance),
      .item      (in_item_ff),
      .read_data (regs_rdata),
      .line_cfg  (line_cfg)
   );

   dltr_timing #(
      .VISIBLE_LINES (VISIBLE_LINES)
   ) u_timing (
      .clock     (clock),
      .reset     (reset),
      .step      (advance),
      .item      (in_item_ff),
      .line_cfg  (line_cfg),
      .read_data (tim_rdata),
      .events    (events)
   );

   assign id_rdata = (in_item_ff.address == ADDR_MODEL_ID) ?
                     (color_ff ? ID_COLOR : ID_MONO) : '0;

   always_comb begin
      out_item_in.read_data = (in_item_ff.kind == KIND_READ) ?
                              (regs_rdata | tim_rdata | id_rdata) : '0;
      out_item_in.vblank_irq       = events.vblank_irq;
      out_item_in.vblank_timer_irq = events.vblank_timer_irq;
      out_item_in.hblank_timer_irq = events.hblank_timer_irq;
      out_item_in.line_hit_irq     = events.line_hit_irq;
      out_item_in.frame_end        = events.frame_end;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
         color_ff   <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
         if (csr_write_enable) begin
            color_ff <= csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_item_ff <= req_payload;
      end
      if (advance) begin
         out_item_ff <= out_item_in;
      end
   end

   assign rsp_valid   = out_vld_ff;
   assign rsp_payload = out_item_ff;

endmodule

[verif/tb_top.sv]
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import dltr_pkg::*;

   localparam logic [1:0] KIND_NONE = 2'd3;
   localparam logic [ADDR_W-1:0] ADDR_PORT_00 = 8'h00;
   localparam logic [ADDR_W-1:0] ADDR_PORT_01 = 8'h01;
   localparam logic [ADDR_W-1:0] ADDR_TMR_GAP = 8'hA3;
   localparam logic [ADDR_W-1:0] ADDR_UNMAPPED = 8'hFF;
   localparam int HALF_PERIOD = 2;
   localparam int RESET_CYCLES = 6;
   localparam int DRAIN_CYCLES = 8;
   localparam int CYCLE_LIMIT = 250000;
   localparam int MAX_PRINTED = 60;
   localparam int DIR_ROWS = 25;

   typedef struct {
      req_type           r;
      bit                fixed;
      logic [DATA_W-1:0] data;
   } dir_row_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_payload;
   logic    csr_write_enable = 1'b0;
   logic    csr_write_data = 1'b0;

   bit idle_on = 1'b1;
   int stall_left = 0;
   int failures = 0;
   int cycle_count = 0;
   rsp_type expected_port_results [$];

   // Shadow copy of the register file, timers and line counter.
   bit                 model_color = 1'b0;
   logic [LINE_W-1:0]  line_now = '0;
   logic [LINE_W-1:0]  line_cmp = LINE_CMP_RESET;
   logic [LINE_W-1:0]  vtotal = VTOTAL_RESET;
   logic [DATA_W-1:0]  tctrl = '0;
   logic [TIMER_W-1:0] hper = '0;
   logic [TIMER_W-1:0] vper = '0;
   logic [TIMER_W-1:0] hcnt = '0;
   logic [TIMER_W-1:0] vcnt = '0;
   logic [DATA_W-1:0]  plain_regs [22] = '{default: '0};
   logic [3:0]         shade_nib [8] = '{default: '0};
   logic [2:0]         mono_ent [64] = '{default: '0};

   dir_row_type directed_rows [DIR_ROWS] = '{
      '{'{KIND_READ,  ADDR_MODEL_ID,    8'h00}, 1'b1, ID_MONO},
      '{'{KIND_READ,  ADDR_LINE_CMP,    8'h00}, 1'b1, LINE_CMP_RESET},
      '{'{KIND_READ,  ADDR_VTOTAL,      8'h00}, 1'b1, VTOTAL_RESET},
      '{'{KIND_READ,  ADDR_LINE,        8'h00}, 1'b1, 8'h00},
      '{'{KIND_READ,  ADDR_UNMAPPED,    8'h00}, 1'b1, 8'h00},
      '{'{KIND_NONE,  ADDR_UNMAPPED,    8'hFF}, 1'b1, 8'h00},
      '{'{KIND_WRITE, ADDR_SPRITE_BASE, 8'hFF}, 1'b1, 8'h00},
      '{'{KIND_READ,  ADDR_SPRITE_BASE, 8'h00}, 1'b1, 8'h3F},
      '{'{KIND_WRITE, ADDR_LAST_PLAIN,  8'hA5}, 1'b1, 8'h00},
      '{'{KIND_READ,  ADDR_LAST_PLAIN,  8'h00}, 1'b1, 8'hA5},
      '{'{KIND_WRITE, ADDR_SHADE_LO,    8'hF1}, 1'b1, 8'h00},
      '{'{KIND_READ,  ADDR_SHADE_LO,    8'h00}, 1'b1, 8'hF1},
      '{'{KIND_WRITE, ADDR_MONO_HI,     8'hFF}, 1'b1, 8'h00},
      '{'{KIND_READ,  ADDR_MONO_HI,     8'h00}, 1'b1, 8'h77},
      '{'{KIND_WRITE, ADDR_LINE,        8'h55}, 1'b1, 8'h00},
      '{'{KIND_WRITE, ADDR_HCNT_HI,     8'hFF}, 1'b1, 8'h00},
      '{'{KIND_WRITE, ADDR_TMR_CTRL,    8'h0F}, 1'b1, 8'h00},
      '{'{KIND_WRITE, ADDR_HPER_LO,     8'h02}, 1'b1, 8'h00},
      '{'{KIND_WRITE, ADDR_HPER_HI,     8'h00}, 1'b1, 8'h00},
      '{'{KIND_TICK,  ADDR_PORT_00,     8'h00}, 1'b0, 8'h00},
      '{'{KIND_TICK,  ADDR_PORT_00,     8'h00}, 1'b0, 8'h00},
      '{'{KIND_READ,  ADDR_HCNT_LO,     8'h00}, 1'b1, 8'h02},
      '{'{KIND_WRITE, ADDR_LINE_CMP,    8'h03}, 1'b1, 8'h00},
      '{'{KIND_TICK,  ADDR_PORT_00,     8'h00}, 1'b0, 8'h00},
      '{'{KIND_WRITE, ADDR_VTOTAL,      8'hFF}, 1'b1, 8'h00}
   };

   display_line_timer_registers_unit dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_payload      (req_payload),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_payload      (rsp_payload),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always #(HALF_PERIOD) clock = ~clock;

   function automatic int plain_slot(logic [ADDR_W-1:0] a);
      if (a <= ADDR_PORT_01) return int'(a);
      if (a >= ADDR_SPRITE_BASE && a <= ADDR_PLAIN_HI)
         return int'(a) - int'(ADDR_SPRITE_BASE) + 2;
      if (a == ADDR_LAST_PLAIN) return 21;
      return -1;
   endfunction

   function automatic logic [DATA_W-1:0] port_value(logic [ADDR_W-1:0] a);
      int s;
      logic [2:0] si;
      logic [5:0] mi;
      si = 3'((a - ADDR_SHADE_LO) << 1);
      mi = 6'((a - ADDR_MONO_LO) << 1);
      s = plain_slot(a);
      if (a >= ADDR_SHADE_LO && a <= ADDR_SHADE_HI)
         return {shade_nib[si + 3'd1], shade_nib[si]};
      if (a >= ADDR_MONO_LO && a <= ADDR_MONO_HI)
         return {1'b0, mono_ent[mi + 6'd1], 1'b0, mono_ent[mi]};
      if (s >= 0) return plain_regs[s];
      case (a)
         ADDR_LINE:     return line_now;
         ADDR_LINE_CMP: return line_cmp;
         ADDR_VTOTAL:   return vtotal;
         ADDR_MODEL_ID: return model_color ? ID_COLOR : ID_MONO;
         ADDR_TMR_CTRL: return tctrl;
         ADDR_HPER_LO:  return hper[7:0];
         ADDR_HPER_HI:  return hper[15:8];
         ADDR_VPER_LO:  return vper[7:0];
         ADDR_VPER_HI:  return vper[15:8];
         ADDR_HCNT_LO:  return hcnt[7:0];
         ADDR_HCNT_HI:  return hcnt[15:8];
         ADDR_VCNT_LO:  return vcnt[7:0];
         ADDR_VCNT_HI:  return vcnt[15:8];
         default:       return '0;
      endcase
   endfunction

   function automatic void store_port(logic [ADDR_W-1:0] a, logic [DATA_W-1:0] v);
      int s;
      logic [2:0] si;
      logic [5:0] mi;
      si = 3'((a - ADDR_SHADE_LO) << 1);
      mi = 6'((a - ADDR_MONO_LO) << 1);
      s = plain_slot(a);
      if (a >= ADDR_SHADE_LO && a <= ADDR_SHADE_HI) begin
         shade_nib[si] = v[3:0];
         shade_nib[si + 3'd1] = v[7:4];
      end else if (a >= ADDR_MONO_LO && a <= ADDR_MONO_HI) begin
         mono_ent[mi] = v[2:0];
         mono_ent[mi + 6'd1] = v[6:4];
      end else if (s >= 0) begin
         plain_regs[s] = (a == ADDR_SPRITE_BASE) ? (v & SPRITE_BASE_MASK) : v;
      end else begin
         case (a)
            ADDR_LINE_CMP: line_cmp = v;
            ADDR_VTOTAL:   vtotal = v;
            ADDR_TMR_CTRL: tctrl = v;
            ADDR_HPER_LO:  hper[7:0] = v;
            ADDR_HPER_HI: begin
               hper[15:8] = v;
               hcnt = hper;
            end
            ADDR_VPER_LO:  vper[7:0] = v;
            ADDR_VPER_HI: begin
               vper[15:8] = v;
               vcnt = vper;
            end
            default: ;
         endcase
      end
   endfunction

   // Applies one item to the shadow state and returns the result it must produce.
   function automatic rsp_type advance_display(req_type r);
      rsp_type res;
      int limit;
      res = '0;
      case (r.kind)
         KIND_READ:  res.read_data = port_value(r.address);
         KIND_WRITE: store_port(r.address, r.write_data);
         KIND_TICK: begin
            if (line_now == LINE_W'(VISIBLE_LINES_DEFAULT)) begin
               res.frame_end = 1'b1;
               res.vblank_irq = 1'b1;
               if (vcnt != '0 && tctrl[TC_VBLANK_EN]) begin
                  vcnt = vcnt - 16'd1;
                  if (vcnt == '0) begin
                     if (tctrl[TC_VBLANK_LOOP]) vcnt = vper;
                     res.vblank_timer_irq = 1'b1;
                  end
               end
            end
            if (hcnt != '0 && tctrl[TC_HBLANK_EN]) begin
               hcnt = hcnt - 16'd1;
               if (hcnt == '0) begin
                  if (tctrl[TC_HBLANK_LOOP]) hcnt = hper;
                  res.hblank_timer_irq = 1'b1;
               end
            end
            limit = ((int'(vtotal) >= VISIBLE_LINES_DEFAULT) ? int'(vtotal)
                                                              : VISIBLE_LINES_DEFAULT) + 1;
            line_now = LINE_W'((int'(line_now) + 1) % limit);
            if (line_now == line_cmp) res.line_hit_irq = 1'b1;
         end
         default: ;
      endcase
      return res;
   endfunction

   function automatic req_type make_req(logic [1:0] k, logic [ADDR_W-1:0] a,
                                        logic [DATA_W-1:0] d);
      req_type r;
      r.kind = k;
      r.address = a;
      r.write_data = d;
      return r;
   endfunction

   function automatic logic [ADDR_W-1:0] pick_port();
      case ($urandom_range(0, 7))
         0: return ADDR_W'($urandom_range(ADDR_SPRITE_BASE, ADDR_PLAIN_HI));
         1: case ($urandom_range(0, 2))
               0: return ADDR_PORT_00;
               1: return ADDR_PORT_01;
               default: return ADDR_LAST_PLAIN;
            endcase
         2: return ADDR_W'($urandom_range(ADDR_SHADE_LO, ADDR_SHADE_HI));
         3: return ADDR_W'($urandom_range(ADDR_MONO_LO, ADDR_MONO_HI));
         4: return ADDR_W'($urandom_range(ADDR_TMR_CTRL, ADDR_VPER_HI));
         5: case ($urandom_range(0, 3))
               0: return ADDR_LINE;
               1: return ADDR_MODEL_ID;
               2: return ADDR_TMR_GAP;
               default: return ADDR_W'($urandom_range(ADDR_HCNT_LO, ADDR_VCNT_HI));
            endcase
         6: return $urandom_range(0, 1) ? ADDR_LINE_CMP : ADDR_VTOTAL;
         default: return ADDR_W'($urandom);
      endcase
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      if (failures < MAX_PRINTED)
         $display("mismatch at cycle %0d: %s got %0h, expected %0h",
                  cycle_count, what, got, want);
      failures++;
   endtask

   // Holds the item on the bus until it is taken; valid stays high afterwards
   // so that the next item can follow without a gap.
   task automatic send_item(req_type r, bit fixed = 1'b0, logic [DATA_W-1:0] fixed_data = '0);
      rsp_type res;
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      res = advance_display(r);
      if (fixed) begin
         res = '0;
         res.read_data = fixed_data;
      end
      expected_port_results.push_back(res);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (expected_port_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_color_model(bit v);
      drain_results();
      csr_write_enable <= 1'b1;
      csr_write_data <= v;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      model_color = v;
   endtask

   task automatic run_random(int budget);
      int sent;
      int n;
      logic [ADDR_W-1:0] a;
      sent = 0;
      while (sent < budget) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
               n = $urandom_range(1, 40);
               repeat (n) send_item(make_req(KIND_TICK, ADDR_W'($urandom), DATA_W'($urandom)));
               sent += n;
            end
            4: begin
               // Mostly short periods so that the timers can expire.
               send_item(make_req(KIND_WRITE, ADDR_TMR_CTRL, DATA_W'($urandom)));
               send_item(make_req(KIND_WRITE, ADDR_HPER_LO, DATA_W'($urandom_range(0, 5))));
               send_item(make_req(KIND_WRITE, ADDR_HPER_HI,
                                  ($urandom_range(0, 7) == 0) ? DATA_W'($urandom) : '0));
               send_item(make_req(KIND_WRITE, ADDR_VPER_LO, DATA_W'($urandom_range(0, 3))));
               send_item(make_req(KIND_WRITE, ADDR_VPER_HI,
                                  ($urandom_range(0, 7) == 0) ? DATA_W'($urandom) : '0));
               sent += 5;
            end
            5: begin
               case ($urandom_range(0, 5))
                  0: a = 8'd0;
                  1: a = 8'd143;
                  2: a = 8'd144;
                  3: a = 8'd145;
                  4: a = 8'd255;
                  default: a = ADDR_W'($urandom);
               endcase
               send_item(make_req(KIND_WRITE, ADDR_VTOTAL, a));
               send_item(make_req(KIND_WRITE, ADDR_LINE_CMP,
                                  $urandom_range(0, 1) ? DATA_W'($urandom_range(0, 160))
                                                       : DATA_W'($urandom)));
               sent += 2;
            end
            6, 7: begin
               a = pick_port();
               send_item(make_req(KIND_WRITE, a, DATA_W'($urandom)));
               send_item(make_req(KIND_READ, a, DATA_W'($urandom)));
               sent += 2;
            end
            8: begin
               n = $urandom_range(1, 4);
               repeat (n) send_item(make_req(KIND_READ, pick_port(), DATA_W'($urandom)));
               sent += n;
            end
            default: begin
               send_item(make_req(2'($urandom), ADDR_W'($urandom), DATA_W'($urandom)));
               sent += 1;
            end
         endcase
      end
   endtask

   // Result side: random stall bursts while idling is on, otherwise ready once any running burst ends.
   always @(posedge clock) begin
      if (stall_left > 0) begin
         rsp_ready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
         rsp_ready <= 1'b0;
         stall_left <= $urandom_range(0, 15);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin : result_check
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_port_results.size() == 0) begin
            report_mismatch("result with none outstanding", int'(rsp_payload), 0);
         end else begin
            want = expected_port_results.pop_front();
            if (rsp_payload.read_data !== want.read_data)
               report_mismatch("read_data", rsp_payload.read_data, want.read_data);
            if (rsp_payload.vblank_irq !== want.vblank_irq)
               report_mismatch("vblank_irq", rsp_payload.vblank_irq, want.vblank_irq);
            if (rsp_payload.vblank_timer_irq !== want.vblank_timer_irq)
               report_mismatch("vblank_timer_irq", rsp_payload.vblank_timer_irq,
                               want.vblank_timer_irq);
            if (rsp_payload.hblank_timer_irq !== want.hblank_timer_irq)
               report_mismatch("hblank_timer_irq", rsp_payload.hblank_timer_irq,
                               want.hblank_timer_irq);
            if (rsp_payload.line_hit_irq !== want.line_hit_irq)
               report_mismatch("line_hit_irq", rsp_payload.line_hit_irq, want.line_hit_irq);
            if (rsp_payload.frame_end !== want.frame_end)
               report_mismatch("frame_end", rsp_payload.frame_end, want.frame_end);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb_top NOT OK");
         $finish;
      end
   end

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      set_color_model(1'b0);
      for (int i = 0; i < DIR_ROWS; i++)
         send_item(directed_rows[i].r, directed_rows[i].fixed, directed_rows[i].data);

      set_color_model(1'b1);
      send_item(make_req(KIND_READ, ADDR_MODEL_ID, '0), 1'b1, ID_COLOR);
      run_random(50);

      set_color_model(1'b0);
      run_random(50);

      // Last stretch at full rate: a long run of ticks at the largest total, so
      // the line passes the end of frame and wraps from 255 back to 0.
      set_color_model(1'b1);
      idle_on = 1'b0;
      send_item(make_req(KIND_WRITE, ADDR_VTOTAL, 8'hFF));
      send_item(make_req(KIND_WRITE, ADDR_TMR_CTRL, 8'h0F));
      send_item(make_req(KIND_WRITE, ADDR_VPER_LO, 8'h01));
      send_item(make_req(KIND_WRITE, ADDR_VPER_HI, 8'h00));
      send_item(make_req(KIND_WRITE, ADDR_HPER_LO, DATA_W'($urandom_range(1, 9))));
      send_item(make_req(KIND_WRITE, ADDR_HPER_HI, 8'h00));
      repeat (260) begin
         send_item(make_req(KIND_TICK, ADDR_W'($urandom), DATA_W'($urandom)));
         if ($urandom_range(0, 9) == 0)
            send_item(make_req(KIND_READ, pick_port(), DATA_W'($urandom)));
      end

      drain_results();
      if (failures == 0) begin
         $display("tb_top OK");
      end else begin
         $display("tb_top NOT OK");
      end
      $finish;
   end

endmodule
